// File: rtl/vang_pkg.sv
// Types, widths and tables shared by the vector angle block.
package vang_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NUM_ITER     = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;
    localparam int MAG_WIDTH   = PROD_WIDTH;
    localparam int CORDIC_IN_WIDTH = 32;
    localparam int NORM_WIDTH  = (MAG_WIDTH > CORDIC_IN_WIDTH) ? MAG_WIDTH : CORDIC_IN_WIDTH;
    localparam int NORM_STAGES = $clog2(NORM_WIDTH);

    localparam int XY_WIDTH      = CORDIC_IN_WIDTH + 3;
    localparam int ANG_ACC_WIDTH = 33;
    localparam int ANGLE_WIDTH   = 16;

    localparam int ACC_QUARTER   = 2 ** 30;
    localparam int ROUND_BIAS    = 2 ** 15;
    localparam int ROUND_SHIFT   = 16;
    localparam int ANGLE_QUARTER = 16384;
    localparam int ANGLE_HALF    = 32768;

    localparam int QUEUE_DEPTH = 4;

    // Load stage, normalize stages, CORDIC load stage, CORDIC iterations.
    localparam int BACK_STAGES = NORM_STAGES + NUM_ITER + 2;

    // atan(2^-i) in units of pi / 2^31.
    localparam logic [31:0] ATAN_UNITS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
    } vang_pair_t;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] angle;
        logic                   degenerate;
    } vang_result_t;

    // One classified item waiting for the back end.
    typedef struct packed {
        logic [MAG_WIDTH-1:0] dot_mag;
        logic [MAG_WIDTH-1:0] cross_mag;
        logic                 dot_neg;
        logic                 degenerate;
    } vang_job_t;

    // Flags that ride along the back-end pipeline.
    typedef struct packed {
        logic dot_neg;
        logic degenerate;
        logic null_vec;
    } vang_meta_t;

endpackage

// File: rtl/vector_angle_2d.sv
// Top level of the 2D vector angle block: front end, job queue, back end.
//
// Takes one pair of 2D vectors per item and returns the unsigned angle between
// them in units of pi/32768 (0..32768), computed as atan2(|cross|, dot) with a
// fixed-step CORDIC vectoring pipeline. If either vector is zero the result
// has degenerate set and angle 0. The block accepts one item per clock and
// returns one result per clock when result_ready stays high. From accept to
// result_valid an item passes, in order, the front-end product register (four
// 16x16 products, loaded at the accepting edge), the queue entry register, a
// load stage, five leading-one normalize stages (one per shift bit of the
// 32-bit word), a CORDIC load stage, sixteen CORDIC iteration stages and the
// output register. The front end feeds a four-entry queue, so it keeps taking
// items for a while when the consumer stalls; the back end pipeline holds as
// one unit while a result waits. pair_ready depends only on queue space and
// the front register, never combinationally on result_ready.
module vector_angle_2d (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pair_valid,
    output logic                   pair_ready,
    input  vang_pkg::vang_pair_t   pair,
    output logic                   result_valid,
    input  logic                   result_ready,
    output vang_pkg::vang_result_t result
);
    import vang_pkg::*;

    logic      front_valid;
    logic      front_ready;
    vang_job_t front_job;
    logic      back_valid;
    logic      back_ready;
    vang_job_t back_job;

    // Classify: products, dot and cross in sign-magnitude form.
    vang_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair),
        .job_valid  (front_valid),
        .job_ready  (front_ready),
        .job        (front_job)
    );

    // Decouple the two halves so each can stall on its own.
    vang_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    // Normalize, rotate and round; owns the output register.
    vang_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (back_valid),
        .job_ready    (back_ready),
        .job          (back_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: rtl/vang_front.sv
// Front end: accept a vector pair, form products, classify into a job.
module vang_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pair_valid,
    output logic               pair_ready,
    input  vang_pkg::vang_pair_t pair,
    output logic               job_valid,
    input  logic               job_ready,
    output vang_pkg::vang_job_t  job
);
    import vang_pkg::*;

    logic                         valid_reg;
    logic                         degen_reg;
    logic signed [PROD_WIDTH-1:0] p_xx_reg;
    logic signed [PROD_WIDTH-1:0] p_yy_reg;
    logic signed [PROD_WIDTH-1:0] p_xy_reg;
    logic signed [PROD_WIDTH-1:0] p_yx_reg;

    logic signed [SUM_WIDTH-1:0] dot_sum;
    logic signed [SUM_WIDTH-1:0] cross_sum;
    logic signed [SUM_WIDTH-1:0] dot_negated;
    logic signed [SUM_WIDTH-1:0] cross_negated;
    logic                        load;

    assign pair_ready = !valid_reg || job_ready;
    assign load       = pair_valid && pair_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pair_ready)
        begin
            valid_reg <= pair_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_xx_reg  <= pair.first_x * pair.second_x;
            p_yy_reg  <= pair.first_y * pair.second_y;
            p_xy_reg  <= pair.first_x * pair.second_y;
            p_yx_reg  <= pair.first_y * pair.second_x;
            degen_reg <= (pair.first_x == '0 && pair.first_y == '0) ||
                         (pair.second_x == '0 && pair.second_y == '0);
        end
    end

    always_comb
    begin
        dot_sum   = {p_xx_reg[PROD_WIDTH-1], p_xx_reg} + {p_yy_reg[PROD_WIDTH-1], p_yy_reg};
        cross_sum = {p_xy_reg[PROD_WIDTH-1], p_xy_reg} - {p_yx_reg[PROD_WIDTH-1], p_yx_reg};
        dot_negated   = -dot_sum;
        cross_negated = -cross_sum;

        job.dot_mag    = dot_sum[SUM_WIDTH-1] ? dot_negated[MAG_WIDTH-1:0]
                                              : dot_sum[MAG_WIDTH-1:0];
        job.cross_mag  = cross_sum[SUM_WIDTH-1] ? cross_negated[MAG_WIDTH-1:0]
                                                : cross_sum[MAG_WIDTH-1:0];
        job.dot_neg    = dot_sum[SUM_WIDTH-1];
        job.degenerate = degen_reg;
    end

    assign job_valid = valid_reg;

endmodule

// File: rtl/vang_queue.sv
// Short job queue between the front end and the back end.
module vang_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  vang_pkg::vang_job_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output vang_pkg::vang_job_t pop_data
);
    import vang_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    vang_job_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/vang_back.sv
// Back end: normalize magnitudes, run CORDIC vectoring, round the angle.
module vang_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  vang_pkg::vang_job_t    job,
    output logic                   result_valid,
    input  logic                   result_ready,
    output vang_pkg::vang_result_t result
);
    import vang_pkg::*;

    logic                 advance;
    logic                 valid_reg [BACK_STAGES];
    vang_meta_t           meta_reg  [BACK_STAGES];
    vang_meta_t           meta_next [BACK_STAGES];

    logic [NORM_WIDTH-1:0] nd_reg  [NORM_STAGES+1];
    logic [NORM_WIDTH-1:0] nc_reg  [NORM_STAGES+1];
    logic [NORM_WIDTH-1:0] nm_reg  [NORM_STAGES+1];
    logic [NORM_WIDTH-1:0] nd_next [NORM_STAGES+1];
    logic [NORM_WIDTH-1:0] nc_next [NORM_STAGES+1];
    logic [NORM_WIDTH-1:0] nm_next [NORM_STAGES+1];

    logic signed [XY_WIDTH-1:0]      cx_reg  [NUM_ITER+1];
    logic signed [XY_WIDTH-1:0]      cy_reg  [NUM_ITER+1];
    logic signed [ANG_ACC_WIDTH-1:0] cz_reg  [NUM_ITER+1];
    logic signed [XY_WIDTH-1:0]      cx_next [NUM_ITER+1];
    logic signed [XY_WIDTH-1:0]      cy_next [NUM_ITER+1];
    logic signed [ANG_ACC_WIDTH-1:0] cz_next [NUM_ITER+1];

    logic                            out_valid_reg;
    vang_result_t                    out_reg;
    vang_result_t                    out_next;
    logic signed [ANG_ACC_WIDTH-1:0] z_final;
    logic signed [ANG_ACC_WIDTH-1:0] z_clamped;
    logic [ANG_ACC_WIDTH-1:0]        round_sum;
    logic [ANGLE_WIDTH-1:0]          quad;
    vang_meta_t                      meta_last;

    // The whole back pipeline moves together; hold it while the result waits.
    assign advance      = !out_valid_reg || result_ready;
    assign job_ready    = advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Normalize: shift until the larger magnitude has its top bit set.
    always_comb
    begin
        int shift;
        nd_next[0] = NORM_WIDTH'(job.dot_mag);
        nc_next[0] = NORM_WIDTH'(job.cross_mag);
        nm_next[0] = (job.dot_mag > job.cross_mag) ? NORM_WIDTH'(job.dot_mag)
                                                   : NORM_WIDTH'(job.cross_mag);
        for (int j = 0; j < NORM_STAGES; j++)
        begin
            shift = 1 << (NORM_STAGES - 1 - j);
            if ((nm_reg[j] >> (NORM_WIDTH - shift)) == '0)
            begin
                nd_next[j+1] = nd_reg[j] << shift;
                nc_next[j+1] = nc_reg[j] << shift;
                nm_next[j+1] = nm_reg[j] << shift;
            end
            else
            begin
                nd_next[j+1] = nd_reg[j];
                nc_next[j+1] = nc_reg[j];
                nm_next[j+1] = nm_reg[j];
            end
        end
    end

    // CORDIC vectoring: drive y toward zero, accumulate the rotation.
    always_comb
    begin
        logic signed [XY_WIDTH-1:0] xs;
        logic signed [XY_WIDTH-1:0] ys;
        logic signed [ANG_ACC_WIDTH-1:0] step;
        cx_next[0] = signed'({{(XY_WIDTH-CORDIC_IN_WIDTH){1'b0}},
                              nd_reg[NORM_STAGES][NORM_WIDTH-1 -: CORDIC_IN_WIDTH]});
        cy_next[0] = signed'({{(XY_WIDTH-CORDIC_IN_WIDTH){1'b0}},
                              nc_reg[NORM_STAGES][NORM_WIDTH-1 -: CORDIC_IN_WIDTH]});
        cz_next[0] = '0;
        for (int i = 0; i < NUM_ITER; i++)
        begin
            xs   = cx_reg[i] >>> i;
            ys   = cy_reg[i] >>> i;
            step = signed'(ANG_ACC_WIDTH'(ATAN_UNITS[i]));
            if (!cy_reg[i][XY_WIDTH-1])
            begin
                cx_next[i+1] = cx_reg[i] + ys;
                cy_next[i+1] = cy_reg[i] - xs;
                cz_next[i+1] = cz_reg[i] + step;
            end
            else
            begin
                cx_next[i+1] = cx_reg[i] - ys;
                cy_next[i+1] = cy_reg[i] + xs;
                cz_next[i+1] = cz_reg[i] - step;
            end
        end
    end

    always_comb
    begin
        meta_next[0].dot_neg    = job.dot_neg;
        meta_next[0].degenerate = job.degenerate;
        meta_next[0].null_vec   = (job.dot_mag == '0) && (job.cross_mag == '0);
        for (int k = 1; k < BACK_STAGES; k++)
        begin
            meta_next[k] = meta_reg[k-1];
        end
    end

    // Clamp to the first quadrant, round to pi/32768, reflect for negative dot; a null vector gives 0.
    always_comb
    begin
        z_final   = cz_reg[NUM_ITER];
        meta_last = meta_reg[BACK_STAGES-1];
        if (z_final < 0)
        begin
            z_clamped = '0;
        end
        else if (z_final > ACC_QUARTER)
        begin
            z_clamped = ANG_ACC_WIDTH'(ACC_QUARTER);
        end
        else
        begin
            z_clamped = z_final;
        end
        round_sum = unsigned'(z_clamped) + ANG_ACC_WIDTH'(ROUND_BIAS);
        quad      = ANGLE_WIDTH'(round_sum >> ROUND_SHIFT);
        if (quad > ANGLE_WIDTH'(ANGLE_QUARTER))
        begin
            quad = ANGLE_WIDTH'(ANGLE_QUARTER);
        end
        out_next.degenerate = meta_last.degenerate;
        if (meta_last.null_vec)
        begin
            out_next.angle = '0;
        end
        else if (meta_last.dot_neg)
        begin
            out_next.angle = ANGLE_WIDTH'(ANGLE_HALF) - quad;
        end
        else
        begin
            out_next.angle = quad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BACK_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= job_valid;
            for (int k = 1; k < BACK_STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            out_valid_reg <= valid_reg[BACK_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < BACK_STAGES; k++)
            begin
                meta_reg[k] <= meta_next[k];
            end
            for (int j = 0; j <= NORM_STAGES; j++)
            begin
                nd_reg[j] <= nd_next[j];
                nc_reg[j] <= nc_next[j];
                nm_reg[j] <= nm_next[j];
            end
            for (int i = 0; i <= NUM_ITER; i++)
            begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/vang_checker.sv
// Port-level checks for the vector angle block, bound to the top level.
module vang_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   pair_valid,
    input logic                   pair_ready,
    input vang_pkg::vang_pair_t   pair,
    input logic                   result_valid,
    input logic                   result_ready,
    input vang_pkg::vang_result_t result
);
    import vang_pkg::*;

    localparam int CAPACITY = QUEUE_DEPTH + BACK_STAGES + 2;
    localparam int CNT_W    = $clog2(CAPACITY + 2);

    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;
    logic             in_take;
    logic             out_take;
    logic             pair_seen;

    assign in_take   = pair_valid && pair_ready;
    assign out_take  = result_valid && result_ready;
    assign pair_seen = (pair.first_x == pair.first_x);

    always_comb
    begin
        pending_next = pending_reg;
        if (in_take && !out_take)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_take && !in_take)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A result must belong to an item that went in and is not yet delivered.
    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pending_reg != '0) && pair_seen)
        else $error("result shown with no item outstanding");

    // Never hold more items than the front, queue and pipeline can store.
    a_bounded_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(CAPACITY))
        else $error("more items in flight than the block can hold");

    // Angle stays within 0..pi, and a zero vector gives angle 0.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.angle <= ANGLE_WIDTH'(ANGLE_HALF)) &&
                         (!result.degenerate || result.angle == '0))
        else $error("angle out of range or degenerate result with nonzero angle");

    // A stalled result stays put.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

endmodule

bind vector_angle_2d vang_checker u_checker (.*);
